>>> hw/rtl/zia_pkg.sv
// Shared types and constants for the zone ID allocator.
package zia_pkg;

    localparam int NUM_ZONES = 16;
    localparam int ZONE_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [DATA_W-1:0] ZONE_SIZE_DEF = 32'd268435456;

    typedef enum logic [2:0] {
        OP_READ      = 3'd0,
        OP_WRITE     = 3'd1,
        OP_SET_OWNER = 3'd2,
        OP_INCREMENT = 3'd3,
        OP_ASSIGN    = 3'd4,
        OP_FREE      = 3'd5
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic              used;
        logic [DATA_W-1:0] counter;
        logic [DATA_W-1:0] owner;
    } entry_t;

    typedef struct packed {
        logic start;
        logic step_en;
    } head_ctl_t;

    typedef struct packed {
        logic [ZONE_W-1:0] step;
        logic              last;
    } head_stat_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [ZONE_W-1:0] assigned_zone;
    } result_t;

endpackage

>>> hw/rtl/zone_id_allocator_top.sv
// Zone ID allocator top level: ring of zone cells, head unit and result register.
//
// Input words (op, zone, new_value, used_flag, owner) arrive on in_valid/in_stall;
// one result word (read_value, assigned_zone) leaves on out_valid/out_stall for
// every input word, in order.
// The 16 zone entries sit in a ring of cells that rotates one place per cycle
// while a word is being worked on and the ring is not held. An accepted word is
// applied by the head cell as each zone passes it, over 16 steps, one per zone;
// the result is registered and shows out_valid in the cycle after the sixteenth
// step. A new word is taken only once the last one is through its steps, set by
// the single head unit that sees one zone a cycle while the ring is not held.
// in_stall is high while a word is being worked on. A finished result may wait
// in the output register while the next word is taken; if it is still stalled
// when the next word reaches its last step, the ring holds until it is taken.
// Reset clears the used flags and owners, loads each zone counter with its
// index times ZONE_SIZE and leaves the block idle with no result pending.
module zone_id_allocator_top #(
    parameter logic [zia_pkg::DATA_W-1:0] ZONE_SIZE = zia_pkg::ZONE_SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 op,
    input  logic [zia_pkg::ZONE_W-1:0] zone,
    input  logic [zia_pkg::DATA_W-1:0] new_value,
    input  logic                       used_flag,
    input  logic [zia_pkg::DATA_W-1:0] owner,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [zia_pkg::DATA_W-1:0] read_value,
    output logic [zia_pkg::ZONE_W-1:0] assigned_zone
);

    zia_pkg::state_t     state_reg;
    zia_pkg::state_t     state_next;
    zia_pkg::head_ctl_t  ctl;
    zia_pkg::head_stat_t stat;
    zia_pkg::result_t    result;
    zia_pkg::entry_t     ring_q [zia_pkg::NUM_ZONES];
    zia_pkg::entry_t     ring_d [zia_pkg::NUM_ZONES];
    zia_pkg::entry_t     head_out;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       load_out;
    logic [zia_pkg::DATA_W-1:0] read_value_reg;
    logic [zia_pkg::ZONE_W-1:0] assigned_zone_reg;

    for (genvar i = 0; i < zia_pkg::NUM_ZONES; i++)
    begin : g_ring
        if (i == zia_pkg::NUM_ZONES - 1)
        begin : g_tail
            assign ring_d[i] = head_out;
        end
        else
        begin : g_link
            assign ring_d[i] = ring_q[i+1];
        end

        zia_cell #(
            .INDEX     (zia_pkg::ZONE_W'(i)),
            .ZONE_SIZE (ZONE_SIZE)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (ctl.step_en),
            .d        (ring_d[i]),
            .q        (ring_q[i])
        );
    end

    zia_head u_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .op        (op),
        .zone      (zone),
        .new_value (new_value),
        .used_flag (used_flag),
        .owner     (owner),
        .entry_in  (ring_q[0]),
        .entry_out (head_out),
        .stat      (stat),
        .result    (result)
    );

    assign in_stall = (state_reg != zia_pkg::ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        ctl.start   = 1'b0;
        ctl.step_en = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            zia_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.start  = 1'b1;
                    state_next = zia_pkg::ST_SCAN;
                end
            end
            zia_pkg::ST_SCAN:
            begin
                // hold on the last step while the previous word is still stalled
                ctl.step_en = !(stat.last && out_valid_reg && out_stall);
                if (stat.last && ctl.step_en)
                begin
                    load_out   = 1'b1;
                    state_next = zia_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = zia_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= zia_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            read_value_reg    <= result.read_value;
            assigned_zone_reg <= result.assigned_zone;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_value    = read_value_reg;
    assign assigned_zone = assigned_zone_reg;

    // step count sits at zero whenever no word is in flight
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == zia_pkg::ST_IDLE) |-> (stat.step == '0))
        else $error("step count not at zero while idle");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == zia_pkg::ST_SCAN))
        else $error("accepted word did not start a scan");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == zia_pkg::ST_SCAN && $past(stat.last)))
        else $error("result raised outside the last scan step");

    a_hold_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == zia_pkg::ST_SCAN && !ctl.step_en) |-> (out_valid_reg && out_stall))
        else $error("ring held without a stalled result");

endmodule

>>> hw/rtl/zia_cell.sv
// One zone slot of the rotating ring: holds a zone entry and passes it on each step.
module zia_cell #(
    parameter logic [zia_pkg::ZONE_W-1:0] INDEX     = '0,
    parameter logic [zia_pkg::DATA_W-1:0] ZONE_SIZE = zia_pkg::ZONE_SIZE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  zia_pkg::entry_t d,
    output zia_pkg::entry_t q
);

    localparam logic [2*zia_pkg::DATA_W-1:0] RST_PROD =
        (2*zia_pkg::DATA_W)'(INDEX) * (2*zia_pkg::DATA_W)'(ZONE_SIZE);
    localparam logic [zia_pkg::DATA_W-1:0] RST_COUNT = RST_PROD[zia_pkg::DATA_W-1:0];

    zia_pkg::entry_t entry_reg;
    zia_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = shift_en ? d : entry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.used    <= 1'b0;
            entry_reg.counter <= RST_COUNT;
            entry_reg.owner   <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign q = entry_reg;

endmodule

>>> hw/rtl/zia_head.sv
// Head of the ring: holds the command word and applies it to the zone passing by.
module zia_head (
    input  logic                          clk,
    input  logic                          rst_n,
    input  zia_pkg::head_ctl_t            ctl,
    input  logic [2:0]                    op,
    input  logic [zia_pkg::ZONE_W-1:0]    zone,
    input  logic [zia_pkg::DATA_W-1:0]    new_value,
    input  logic                          used_flag,
    input  logic [zia_pkg::DATA_W-1:0]    owner,
    input  zia_pkg::entry_t               entry_in,
    output zia_pkg::entry_t               entry_out,
    output zia_pkg::head_stat_t           stat,
    output zia_pkg::result_t              result
);

    zia_pkg::op_t                 op_reg;
    logic [zia_pkg::ZONE_W-1:0]   zone_reg;
    logic [zia_pkg::DATA_W-1:0]   value_reg;
    logic                         flag_reg;
    logic [zia_pkg::DATA_W-1:0]   owner_reg;

    logic [zia_pkg::ZONE_W-1:0]   step_reg;
    logic [zia_pkg::ZONE_W-1:0]   step_next;
    logic                         found_reg;
    logic                         found_next;
    logic [zia_pkg::DATA_W-1:0]   rd_reg;
    logic [zia_pkg::DATA_W-1:0]   rd_next;
    logic [zia_pkg::ZONE_W-1:0]   given_reg;
    logic [zia_pkg::ZONE_W-1:0]   given_next;
    logic                         hit;

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            op_reg    <= zia_pkg::op_t'(op);
            zone_reg  <= zone;
            value_reg <= new_value;
            flag_reg  <= used_flag;
            owner_reg <= owner;
        end
    end

    assign hit = (step_reg == zone_reg);

    always_comb
    begin
        entry_out  = entry_in;
        rd_next    = rd_reg;
        given_next = given_reg;
        found_next = found_reg;
        case (op_reg)
            zia_pkg::OP_READ:
            begin
                if (hit)
                    rd_next = entry_in.counter;
            end
            zia_pkg::OP_WRITE:
            begin
                if (hit)
                begin
                    entry_out.counter = value_reg;
                    entry_out.used    = flag_reg;
                end
            end
            zia_pkg::OP_SET_OWNER:
            begin
                if (hit)
                    entry_out.owner = owner_reg;
            end
            zia_pkg::OP_INCREMENT:
            begin
                if (hit)
                    entry_out.counter = entry_in.counter + 32'd1;
            end
            zia_pkg::OP_ASSIGN:
            begin
                // zone 0 is reserved; take the first free one after it
                if (step_reg != '0 && !found_reg && !entry_in.used)
                begin
                    entry_out.used  = 1'b1;
                    entry_out.owner = owner_reg;
                    found_next      = 1'b1;
                    given_next      = step_reg;
                end
            end
            zia_pkg::OP_FREE:
            begin
                if (step_reg != '0 && entry_in.owner == owner_reg)
                begin
                    entry_out.used  = 1'b0;
                    entry_out.owner = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign step_next = step_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            found_reg <= 1'b0;
            rd_reg    <= '0;
            given_reg <= '0;
        end
        else if (ctl.start)
        begin
            step_reg  <= '0;
            found_reg <= 1'b0;
            rd_reg    <= '0;
            given_reg <= '0;
        end
        else if (ctl.step_en)
        begin
            step_reg  <= step_next;
            found_reg <= found_next;
            rd_reg    <= rd_next;
            given_reg <= given_next;
        end
    end

    assign stat.step            = step_reg;
    assign stat.last            = (step_reg == zia_pkg::ZONE_W'(zia_pkg::NUM_ZONES - 1));
    assign result.read_value    = rd_next;
    assign result.assigned_zone = given_next;

endmodule
